[src/entry_move_remap_tracker_unit_defines.svh]
// Assertion macros for the entry move remap tracker.
`ifndef ENTRY_MOVE_REMAP_TRACKER_UNIT_DEFINES_SVH
`define ENTRY_MOVE_REMAP_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define EMRT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define EMRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/emrt_pkg.sv]
// Shared types and constants of the entry move remap tracker.
package emrt_pkg;

	localparam int DEF_TABLE_DEPTH  = 32;
	localparam int DEF_SEGMENT_BITS = 5;
	localparam int DEF_INDEX_BITS   = 7;

	localparam int OP_BITS   = 2;
	localparam int STS_BITS  = 2;
	localparam int SLOT_BITS = 5;

	typedef enum logic [OP_BITS-1:0] {
		OP_BEGIN = 2'd0,
		OP_MOVE  = 2'd1,
		OP_END   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [STS_BITS-1:0] {
		STS_OK      = 2'd0,
		STS_IGNORED = 2'd1,
		STS_FULL    = 2'd2,
		STS_SEQ_ERR = 2'd3
	} sts_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic start_scan;
		logic scan;
		logic read_issue;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		logic needs_scan;
		logic needs_read;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

[src/emrt_in_if.sv]
// Request channel of the remap tracker: valid/ready plus one request item.
interface emrt_in_if #(
	parameter int SEGMENT_BITS = emrt_pkg::DEF_SEGMENT_BITS,
	parameter int INDEX_BITS   = emrt_pkg::DEF_INDEX_BITS
);
	import emrt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_BITS-1:0]      opcode;
	logic                    src_is_file;
	logic [SEGMENT_BITS-1:0] src_segment;
	logic [INDEX_BITS-1:0]   src_index;
	logic [SEGMENT_BITS-1:0] dst_segment;
	logic [INDEX_BITS-1:0]   dst_index;
	logic [SLOT_BITS-1:0]    slot_number;

	modport source (
		output valid, opcode, src_is_file, src_segment, src_index,
		       dst_segment, dst_index, slot_number,
		input  ready
	);

	modport sink (
		input  valid, opcode, src_is_file, src_segment, src_index,
		       dst_segment, dst_index, slot_number,
		output ready
	);
endinterface

[src/emrt_out_if.sv]
// Response channel of the remap tracker: valid/ready plus one response item.
interface emrt_out_if #(
	parameter int TABLE_DEPTH  = emrt_pkg::DEF_TABLE_DEPTH,
	parameter int SEGMENT_BITS = emrt_pkg::DEF_SEGMENT_BITS,
	parameter int INDEX_BITS   = emrt_pkg::DEF_INDEX_BITS
);
	import emrt_pkg::*;

	localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);

	logic                    valid;
	logic                    ready;
	logic [STS_BITS-1:0]     status;
	logic [COUNT_BITS-1:0]   entry_count;
	logic                    merged;
	logic [SEGMENT_BITS-1:0] old_segment_out;
	logic [INDEX_BITS-1:0]   old_index_out;
	logic [SEGMENT_BITS-1:0] new_segment_out;
	logic [INDEX_BITS-1:0]   new_index_out;

	modport source (
		output valid, status, entry_count, merged, old_segment_out, old_index_out,
		       new_segment_out, new_index_out,
		input  ready
	);

	modport sink (
		input  valid, status, entry_count, merged, old_segment_out, old_index_out,
		       new_segment_out, new_index_out,
		output ready
	);
endinterface

[src/entry_move_remap_tracker_unit.sv]
// Top level of the entry move remap tracker: controller plus datapath.
// Each request is taken in idle, then walks start, an optional scan and finish;
// move and end scan the valid entries one slot per cycle through the single read
// port of the remap memory. No new request is taken until the last is committed.
// Reset clears the controller, entry count, open flag, moved flags and response
// valid flag at once; table contents stay undefined, no clearing pass.
`include "entry_move_remap_tracker_unit_defines.svh"

module entry_move_remap_tracker_unit #(
	parameter int TABLE_DEPTH  = emrt_pkg::DEF_TABLE_DEPTH,
	parameter int SEGMENT_BITS = emrt_pkg::DEF_SEGMENT_BITS,
	parameter int INDEX_BITS   = emrt_pkg::DEF_INDEX_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	emrt_in_if.sink    in_ch,
	emrt_out_if.source out_ch
);
	import emrt_pkg::*;

	localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);

	// Command and status between the two halves. The controller walks
	// idle -> start -> (scan) -> finish; the datapath does all the table work:
	//   move: scan slots from 0 for an unmoved entry at the source position,
	//         rewrite it in place, else append at the end on commit
	//   end:  scan all slots, copy non-identity entries down to keep order
	//   read: one registered read of the requested slot
	cmd_t  cmd;
	stat_t stat;

	emrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	emrt_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.SEGMENT_BITS (SEGMENT_BITS),
		.INDEX_BITS   (INDEX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// A committed transaction always shows up on the response channel.
	`EMRT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_ch.valid, "commit lost")
	// Never overwrite a response still waiting to be taken.
	`EMRT_ASSERT_IMPL(a_no_overwrite, cmd.commit, stat.out_free, "response overwritten")
	// No new request is taken while the table is being scanned.
	`EMRT_ASSERT_IMPL(a_no_take_in_scan, cmd.scan, !in_ch.ready, "accept during scan")
	// Reported entry count never exceeds the table depth.
	`EMRT_ASSERT_IMPL(a_count_bound, out_ch.valid,
		out_ch.entry_count <= COUNT_BITS'(TABLE_DEPTH), "entry count overflow")

endmodule

[src/emrt_ctrl.sv]
// Sequencing state machine of the remap tracker.
module emrt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  emrt_pkg::stat_t stat,
	output emrt_pkg::cmd_t  cmd
);
	import emrt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_START  = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (stat.in_valid) begin
					state_nxt = S_START;
				end
			end
			S_START: begin
				if (stat.needs_scan) begin
					cmd.start_scan = 1'b1;
					state_nxt      = S_SCAN;
				end else begin
					cmd.read_issue = stat.needs_read;
					state_nxt      = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the response register can take a new item
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/emrt_dp.sv]
// Datapath of the remap tracker: remap memory, scan pipeline, counters, response register.
module emrt_dp #(
	parameter int TABLE_DEPTH  = emrt_pkg::DEF_TABLE_DEPTH,
	parameter int SEGMENT_BITS = emrt_pkg::DEF_SEGMENT_BITS,
	parameter int INDEX_BITS   = emrt_pkg::DEF_INDEX_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  emrt_pkg::cmd_t  cmd,
	output emrt_pkg::stat_t stat,
	emrt_in_if.sink         in_ch,
	emrt_out_if.source      out_ch
);
	import emrt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = CW + SLOT_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef struct packed {
		logic [SEGMENT_BITS-1:0] old_seg;
		logic [INDEX_BITS-1:0]   old_idx;
		logic [SEGMENT_BITS-1:0] new_seg;
		logic [INDEX_BITS-1:0]   new_idx;
	} entry_t;

	// remap memory, one write and one registered read per cycle
	entry_t remap_mem [TABLE_DEPTH];
	entry_t rd_data_q;
	logic   rd_en;
	logic [AW-1:0] rd_addr;
	logic   wr_en;
	logic [AW-1:0] wr_addr;
	entry_t wr_data;

	// latched request
	op_t                     op_q;
	logic                    file_q;
	logic [SEGMENT_BITS-1:0] src_seg_q;
	logic [INDEX_BITS-1:0]   src_idx_q;
	logic [SEGMENT_BITS-1:0] dst_seg_q;
	logic [INDEX_BITS-1:0]   dst_idx_q;
	logic [SLOT_BITS-1:0]    slot_q;

	// table state
	logic [CW-1:0]          count_q;
	logic                   open_q;
	logic [TABLE_DEPTH-1:0] moved_q;

	// scan pipeline
	logic [CW-1:0] issue_q;
	logic          ev_vld_s1;
	logic [AW-1:0] ev_idx_s1;
	logic [CW-1:0] keep_q;
	logic          found_q;

	// response register
	logic                    out_valid_q;
	sts_t                    sts_q;
	logic [CW-1:0]           cnt_out_q;
	logic                    merged_q;
	entry_t                  slot_out_q;

	logic          issue_more;
	logic          ev_hit;
	logic          ev_home;
	logic          is_move;
	logic          is_end;
	logic [SW-1:0] slot_ext;
	logic          slot_ok;

	sts_t          nxt_sts;
	logic [CW-1:0] nxt_cnt;
	logic          nxt_merged;
	entry_t        nxt_slot;
	logic          app;
	logic          clr_moved;
	logic          set_open;
	logic          clr_open;

	assign is_move    = (op_q == OP_MOVE);
	assign is_end     = (op_q == OP_END);
	assign issue_more = (issue_q < count_q);
	assign ev_hit     = ev_vld_s1 && (rd_data_q.new_seg == src_seg_q) &&
	                    (rd_data_q.new_idx == src_idx_q) && !moved_q[ev_idx_s1];
	assign ev_home    = (rd_data_q.old_seg == rd_data_q.new_seg) &&
	                    (rd_data_q.old_idx == rd_data_q.new_idx);
	assign slot_ext   = SW'(slot_q);
	assign slot_ok    = (slot_ext < SW'(count_q));

	assign stat.in_valid   = in_ch.valid;
	assign stat.needs_scan = open_q && ((is_move && file_q) || is_end);
	assign stat.needs_read = (op_q == OP_READ) && slot_ok;
	assign stat.scan_done  = (is_move && ev_hit) || (!ev_vld_s1 && !issue_more);
	assign stat.out_free   = !out_valid_q || out_ch.ready;

	assign in_ch.ready = cmd.take;

	assign rd_en   = (cmd.scan && issue_more) || cmd.read_issue;
	assign rd_addr = cmd.read_issue ? slot_ext[AW-1:0] : issue_q[AW-1:0];

	// outcome of the latched request, applied on commit
	always_comb begin
		nxt_sts    = STS_OK;
		nxt_cnt    = count_q;
		nxt_merged = 1'b0;
		nxt_slot   = '0;
		app        = 1'b0;
		clr_moved  = 1'b0;
		set_open   = 1'b0;
		clr_open   = 1'b0;
		case (op_q)
			OP_BEGIN: begin
				if (open_q) begin
					nxt_sts = STS_SEQ_ERR;
				end else begin
					clr_moved = 1'b1;
					set_open  = 1'b1;
				end
			end
			OP_MOVE: begin
				if (!open_q) begin
					nxt_sts = STS_SEQ_ERR;
				end else if (!file_q) begin
					nxt_sts = STS_IGNORED;
				end else if (found_q) begin
					nxt_merged = 1'b1;
				end else if (count_q < DEPTH_C) begin
					app     = 1'b1;
					nxt_cnt = count_q + CW'(1);
				end else begin
					nxt_sts = STS_FULL;
				end
			end
			OP_END: begin
				if (!open_q) begin
					nxt_sts = STS_SEQ_ERR;
				end else begin
					clr_open = 1'b1;
					nxt_cnt  = keep_q;
				end
			end
			OP_READ: begin
				if (slot_ok) begin
					nxt_slot = rd_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	// single write port: append, in-place merge, or compaction copy
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ev_idx_s1;
		wr_data = rd_data_q;
		if (cmd.commit && app) begin
			wr_en           = 1'b1;
			wr_addr         = count_q[AW-1:0];
			wr_data.old_seg = src_seg_q;
			wr_data.old_idx = src_idx_q;
			wr_data.new_seg = dst_seg_q;
			wr_data.new_idx = dst_idx_q;
		end else if (cmd.scan) begin
			if (is_move && ev_hit) begin
				wr_en           = 1'b1;
				wr_addr         = ev_idx_s1;
				wr_data.new_seg = dst_seg_q;
				wr_data.new_idx = dst_idx_q;
			end else if (is_end && ev_vld_s1 && !ev_home) begin
				wr_en   = 1'b1;
				wr_addr = keep_q[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			remap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= remap_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && in_ch.valid) begin
			op_q      <= op_t'(in_ch.opcode);
			file_q    <= in_ch.src_is_file;
			src_seg_q <= in_ch.src_segment;
			src_idx_q <= in_ch.src_index;
			dst_seg_q <= in_ch.dst_segment;
			dst_idx_q <= in_ch.dst_index;
			slot_q    <= in_ch.slot_number;
		end
		if (cmd.scan) begin
			ev_idx_s1 <= issue_q[AW-1:0];
		end
		if (cmd.commit) begin
			sts_q      <= nxt_sts;
			cnt_out_q  <= nxt_cnt;
			merged_q   <= nxt_merged;
			slot_out_q <= nxt_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			open_q      <= 1'b0;
			moved_q     <= '0;
			issue_q     <= '0;
			ev_vld_s1   <= 1'b0;
			keep_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_scan) begin
				issue_q   <= '0;
				ev_vld_s1 <= 1'b0;
				keep_q    <= '0;
				found_q   <= 1'b0;
			end
			if (cmd.scan) begin
				issue_q   <= issue_q + CW'(issue_more);
				ev_vld_s1 <= issue_more;
				if (is_move && ev_hit) begin
					found_q            <= 1'b1;
					moved_q[ev_idx_s1] <= 1'b1;
				end
				if (is_end && ev_vld_s1 && !ev_home) begin
					keep_q <= keep_q + CW'(1);
				end
			end
			if (cmd.commit) begin
				count_q <= nxt_cnt;
				if (set_open) begin
					open_q <= 1'b1;
				end
				if (clr_open) begin
					open_q <= 1'b0;
				end
				if (clr_moved) begin
					moved_q <= '0;
				end
				if (app) begin
					moved_q[count_q[AW-1:0]] <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = sts_q;
	assign out_ch.entry_count     = cnt_out_q;
	assign out_ch.merged          = merged_q;
	assign out_ch.old_segment_out = slot_out_q.old_seg;
	assign out_ch.old_index_out   = slot_out_q.old_idx;
	assign out_ch.new_segment_out = slot_out_q.new_seg;
	assign out_ch.new_index_out   = slot_out_q.new_idx;

endmodule

[tb/remap_result_checker.sv]
// Checker for the remap tracker: predicts every response and compares it on the response channel.
`timescale 1ns / 1ps

module remap_result_checker #(
	parameter int TABLE_DEPTH  = emrt_pkg::DEF_TABLE_DEPTH,
	parameter int SEGMENT_BITS = emrt_pkg::DEF_SEGMENT_BITS,
	parameter int INDEX_BITS   = emrt_pkg::DEF_INDEX_BITS
) (
	input  logic clk,
	input  logic arst_n,
	emrt_in_if   in_ch,
	emrt_out_if  out_ch,
	output int   fail_count,
	output int   pending
);
	import emrt_pkg::*;

	localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
	localparam int PRINT_CAP  = 40;

	typedef struct {
		logic [SEGMENT_BITS-1:0] old_seg;
		logic [INDEX_BITS-1:0]   old_idx;
		logic [SEGMENT_BITS-1:0] cur_seg;
		logic [INDEX_BITS-1:0]   cur_idx;
		logic                    moved;
	} remap_t;

	typedef struct {
		sts_t                    status;
		logic [COUNT_BITS-1:0]   count;
		logic                    merged;
		logic [SEGMENT_BITS-1:0] old_seg;
		logic [INDEX_BITS-1:0]   old_idx;
		logic [SEGMENT_BITS-1:0] cur_seg;
		logic [INDEX_BITS-1:0]   cur_idx;
	} reply_t;

	// shadow of the tracker state
	remap_t      remaps [TABLE_DEPTH];
	int unsigned live;
	logic        txn_open;

	reply_t replies_due [$];
	reply_t due_reply;
	int     mismatches = 0;
	int     reply_no;

	assign fail_count = mismatches;

	task automatic note_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("%0t: response %0d: %s got %0d, want %0d", $realtime, reply_no, what, got,
				want);
		mismatches++;
	endtask

	// Updates the shadow table for one request and returns its response.
	function automatic reply_t apply_request(op_t op, logic file,
		logic [SEGMENT_BITS-1:0] ss, logic [INDEX_BITS-1:0] si,
		logic [SEGMENT_BITS-1:0] ds, logic [INDEX_BITS-1:0] di,
		logic [SLOT_BITS-1:0] slot);
		reply_t r;
		int     hit;
		int     keep;
		r.status  = STS_OK;
		r.merged  = 1'b0;
		r.old_seg = '0;
		r.old_idx = '0;
		r.cur_seg = '0;
		r.cur_idx = '0;
		case (op)
			OP_BEGIN: begin
				if (txn_open) begin
					r.status = STS_SEQ_ERR;
				end else begin
					foreach (remaps[i])
						remaps[i].moved = 1'b0;
					txn_open = 1'b1;
				end
			end
			OP_MOVE: begin
				if (!txn_open) begin
					r.status = STS_SEQ_ERR;
				end else if (!file) begin
					r.status = STS_IGNORED;
				end else begin
					// first live entry sitting at the source and not yet moved
					hit = -1;
					for (int i = 0; i < live; i++)
						if (hit < 0 && !remaps[i].moved && remaps[i].cur_seg == ss &&
							remaps[i].cur_idx == si)
							hit = i;
					if (hit >= 0) begin
						remaps[hit].cur_seg = ds;
						remaps[hit].cur_idx = di;
						remaps[hit].moved   = 1'b1;
						r.merged = 1'b1;
					end else if (live < TABLE_DEPTH) begin
						remaps[live] = '{ss, si, ds, di, 1'b1};
						live++;
					end else begin
						r.status = STS_FULL;
					end
				end
			end
			OP_END: begin
				if (!txn_open) begin
					r.status = STS_SEQ_ERR;
				end else begin
					txn_open = 1'b0;
					// drop entries back at their origin, keep order of the rest
					keep = 0;
					for (int i = 0; i < live; i++)
						if (remaps[i].old_seg != remaps[i].cur_seg ||
							remaps[i].old_idx != remaps[i].cur_idx) begin
							remaps[keep] = remaps[i];
							keep++;
						end
					live = keep;
				end
			end
			default: begin
				if (slot < live) begin
					r.old_seg = remaps[slot].old_seg;
					r.old_idx = remaps[slot].old_idx;
					r.cur_seg = remaps[slot].cur_seg;
					r.cur_idx = remaps[slot].cur_idx;
				end
			end
		endcase
		r.count = COUNT_BITS'(live);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live     = 0;
			txn_open = 1'b0;
			foreach (remaps[i])
				remaps[i].moved = 1'b0;
			replies_due.delete();
			reply_no = 0;
			pending <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (replies_due.size() == 0) begin
					note_mismatch("response with nothing outstanding", out_ch.status, 0);
				end else begin
					due_reply = replies_due.pop_front();
					if (out_ch.status != due_reply.status)
						note_mismatch("status", out_ch.status, due_reply.status);
					if (out_ch.entry_count != due_reply.count)
						note_mismatch("entry_count", out_ch.entry_count, due_reply.count);
					if (out_ch.merged != due_reply.merged)
						note_mismatch("merged", out_ch.merged, due_reply.merged);
					if (out_ch.old_segment_out != due_reply.old_seg)
						note_mismatch("old_segment_out", out_ch.old_segment_out,
							due_reply.old_seg);
					if (out_ch.old_index_out != due_reply.old_idx)
						note_mismatch("old_index_out", out_ch.old_index_out, due_reply.old_idx);
					if (out_ch.new_segment_out != due_reply.cur_seg)
						note_mismatch("new_segment_out", out_ch.new_segment_out,
							due_reply.cur_seg);
					if (out_ch.new_index_out != due_reply.cur_idx)
						note_mismatch("new_index_out", out_ch.new_index_out, due_reply.cur_idx);
				end
				reply_no++;
			end
			if (in_ch.valid && in_ch.ready)
				replies_due = {replies_due, apply_request(op_t'(in_ch.opcode),
					in_ch.src_is_file, in_ch.src_segment, in_ch.src_index,
					in_ch.dst_segment, in_ch.dst_index, in_ch.slot_number)};
			pending <= replies_due.size();
		end
	end

endmodule

[tb/entry_move_remap_tracker_unit_tb.sv]
// Testbench top of the remap tracker: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module entry_move_remap_tracker_unit_tb;
	import emrt_pkg::*;

	localparam int SEG_W         = DEF_SEGMENT_BITS;
	localparam int IDX_W         = DEF_INDEX_BITS;
	localparam int RANDOM_ITEMS  = 400;
	// worst item: an idle gap, the scan in the block and a response stall; this is far above
	localparam int CYCLE_LIMIT   = 200000;
	// sized from the table depth, as the longest move/end scans every valid entry
	localparam int SETTLE_CYCLES = DEF_TABLE_DEPTH + 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          fail_count;
	int          pending;
	int unsigned cycles = 0;
	int          sent = 0;
	// when set, neither side idles: back-to-back stretches
	bit          calm = 1'b0;

	emrt_in_if  req_ch ();
	emrt_out_if rsp_ch ();

	entry_move_remap_tracker_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (rsp_ch)
	);

	// predicts and compares; hands back failures and the number of responses still owed
	remap_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (req_ch),
		.out_ch     (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs or loses a response
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// idle cycles before one transaction; at least a third of the draws are zero, all while calm
	function automatic int pick_gap();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Position pool: extremes of both fields plus index 1, so merges and
	// moves back to the origin happen often.
	function automatic logic [SEG_W-1:0] pool_seg();
		return ($urandom_range(0, 1) == 1) ? {SEG_W{1'b1}} : {SEG_W{1'b0}};
	endfunction

	function automatic logic [IDX_W-1:0] pool_idx();
		case ($urandom_range(0, 2))
			0:       return {IDX_W{1'b0}};
			1:       return {IDX_W{1'b1}};
			default: return IDX_W'(1);
		endcase
	endfunction

	// One request transaction: optional idle gap, then hold valid until accepted.
	// valid stays high across back-to-back requests, never dropped and raised in one step.
	task automatic send(op_t op, logic file, logic [SEG_W-1:0] ss, logic [IDX_W-1:0] si,
		logic [SEG_W-1:0] ds, logic [IDX_W-1:0] di, logic [SLOT_BITS-1:0] slot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.src_is_file <= file;
		req_ch.src_segment <= ss;
		req_ch.src_index   <= si;
		req_ch.dst_segment <= ds;
		req_ch.dst_index   <= di;
		req_ch.slot_number <= slot;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// Any opcode with every field random, used for reads and for noise.
	task automatic send_random(op_t op);
		send(op, 1'($urandom_range(0, 1)), SEG_W'($urandom), IDX_W'($urandom),
			SEG_W'($urandom), IDX_W'($urandom), SLOT_BITS'($urandom));
	endtask

	// Move request. Mostly pool positions; now and then full-range positions,
	// which usually land back on the source so they leave at the end.
	task automatic send_move(logic file);
		logic [SEG_W-1:0] ss;
		logic [SEG_W-1:0] ds;
		logic [IDX_W-1:0] si;
		logic [IDX_W-1:0] di;
		if ($urandom_range(0, 9) == 0) begin
			ss = SEG_W'($urandom);
			si = IDX_W'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				ds = ss;
				di = si;
			end else begin
				ds = SEG_W'($urandom);
				di = IDX_W'($urandom);
			end
		end else begin
			ss = pool_seg();
			si = pool_idx();
			ds = pool_seg();
			di = pool_idx();
		end
		send(OP_MOVE, file, ss, si, ds, di, SLOT_BITS'($urandom));
	endtask

	// Stop sending and wait until every response owed has come back. The first
	// edge lets the checker count a transaction accepted at the current one.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Response side: random stall before each transaction, ready held until one lands.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Request side: reset, directed cases, random sessions, drain, verdict.
	initial begin
		int steps;
		int pick;
		int quota;
		bit paused;
		bit first;
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= OP_BEGIN;
		req_ch.src_is_file <= 1'b0;
		req_ch.src_segment <= '0;
		req_ch.src_index   <= '0;
		req_ch.dst_segment <= '0;
		req_ch.dst_index   <= '0;
		req_ch.slot_number <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// read of an empty table, while closed
		send(OP_READ, 1'b0, '0, '0, '0, '0, '0);
		// move and end without an open transaction are sequence errors
		send(OP_MOVE, 1'b1, '1, '1, '0, '0, '0);
		send(OP_END, 1'b0, '0, '0, '0, '0, '0);
		send(OP_BEGIN, 1'b0, '0, '0, '0, '0, '0);
		// begin while already open
		send(OP_BEGIN, 1'b1, '1, '1, '1, '1, '1);
		// non-file move is ignored
		send(OP_MOVE, 1'b0, '0, '0, '1, '1, '0);
		// append (0,0)->(31,127)
		send(OP_MOVE, 1'b1, '0, '0, '1, '1, '0);
		// source matches entry 0, but it moved already: second append
		send(OP_MOVE, 1'b1, '1, '1, '0, '0, '1);
		// move onto itself: appended, gone at the end of the transaction
		send(OP_MOVE, 1'b1, SEG_W'(10), IDX_W'(64), SEG_W'(10), IDX_W'(64), '0);
		// reads while open, the last one past the live entries
		send(OP_READ, 1'b0, '0, '0, '0, '0, SLOT_BITS'(0));
		send(OP_READ, 1'b0, '0, '0, '0, '0, SLOT_BITS'(1));
		send(OP_READ, 1'b1, '1, '1, '1, '1, SLOT_BITS'(2));
		send(OP_READ, 1'b0, '0, '0, '0, '0, '1);
		send(OP_END, 1'b0, '0, '0, '0, '0, '0);
		send(OP_BEGIN, 1'b0, '0, '0, '0, '0, '0);
		// merge sends entry 0 back to its origin
		send(OP_MOVE, 1'b1, '1, '1, '0, '0, '0);
		// entry 0 is now moved, so entry 1 takes this merge
		send(OP_MOVE, 1'b1, '0, '0, SEG_W'(21), IDX_W'(42), '0);
		send(OP_READ, 1'b0, '0, '0, '0, '0, SLOT_BITS'(0));
		send(OP_READ, 1'b0, '0, '0, '0, '0, SLOT_BITS'(1));
		// compaction drops entry 0 and shifts entry 1 down
		send(OP_END, 1'b0, '0, '0, '0, '0, '0);
		send(OP_READ, 1'b0, '0, '0, '0, '0, SLOT_BITS'(0));
		send(OP_READ, 1'b0, '0, '0, '0, '0, '1);

		// ---- random sessions ----
		// Mostly well-formed transactions (begin, moves and reads, end), the rest
		// noise. The first session is long enough to fill the table and hit drops.
		quota  = sent + RANDOM_ITEMS;
		paused = 1'b0;
		first  = 1'b1;
		while (sent < quota) begin
			calm = ($urandom_range(0, 5) == 0);
			if (!first && $urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					send_random(op_t'($urandom_range(0, 3)));
			end else begin
				send_random(OP_BEGIN);
				if (first)
					steps = 48;
				else if ($urandom_range(0, 7) == 0)
					steps = $urandom_range(30, 40);
				else
					steps = $urandom_range(1, 10);
				first = 1'b0;
				repeat (steps) begin
					pick = $urandom_range(0, 19);
					if (pick < 3)
						send_random(OP_READ);
					else if (pick == 3)
						send_move(1'b0);
					else
						send_move(1'b1);
				end
				if ($urandom_range(0, 15) == 0)
					send_random(OP_BEGIN);
				send_random(OP_END);
				repeat ($urandom_range(0, 3))
					send_random(OP_READ);
			end
			// once, halfway: let everything in flight come back before going on
			if (!paused && sent > quota - RANDOM_ITEMS / 2) begin
				wait_idle();
				paused = 1'b1;
			end
		end

		calm = 1'b0;
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
